>>> design/assert_macros.svh
// Assertion macros shared by the stack pool modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/msp_pkg.sv
// Shared types and constants of the shared-pool stack block.
`timescale 1ns / 1ps

package msp_pkg;

    localparam int NUM_STACKS = 4;
    localparam int POOL_SIZE  = 256;

    localparam int DATA_W = 32;
    localparam int SID_W  = 2;
    localparam int IDX_W  = $clog2(POOL_SIZE);
    // Pointer carries one extra bit so that the null code fits
    localparam int PTR_W  = IDX_W + 1;

    localparam logic [PTR_W-1:0] LINK_NULL = PTR_W'(POOL_SIZE);

    // Request kinds
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
    } msp_cmd_t;

endpackage

>>> design/msp_ctrl.sv
// Controller: sequences each request through its read and write-back cycles.
`timescale 1ns / 1ps

module msp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output msp_pkg::msp_cmd_t cmd
);
    import msp_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   busy_reg;

    // Take a request only while idle
    assign cmd.load = start & ~busy_reg;
    assign cmd.exec = (state_reg == S_EXEC);
    assign busy     = busy_reg;

    // Hold state and the busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.load)
                    begin
                        state_reg <= S_EXEC;
                        busy_reg  <= 1'b1;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    `ASSERT_NEXT(a_load_sets_exec, cmd.load, cmd.exec && busy_reg)
    `ASSERT_NEXT(a_exec_one_cycle, cmd.exec, !cmd.exec && !busy_reg)

endmodule

>>> design/msp_dp.sv
// Datapath: pool memories, stack tops, free-list head and result registers.
`timescale 1ns / 1ps

module msp_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  msp_pkg::msp_cmd_t            cmd,
    input  logic                         req_type,
    input  logic [msp_pkg::SID_W-1:0]    stack_id,
    input  logic signed [msp_pkg::DATA_W-1:0] push_value,
    output logic                         done,
    output logic [1:0]                   status,
    output logic signed [msp_pkg::DATA_W-1:0] pop_value
);
    import msp_pkg::*;

    `include "assert_macros.svh"

    // Pool memories
    logic [DATA_W-1:0] data_mem [POOL_SIZE];
    logic [PTR_W-1:0]  link_mem [POOL_SIZE];

    logic [DATA_W-1:0] data_rd_reg;
    logic [PTR_W-1:0]  link_rd_reg;

    // Control state
    logic [PTR_W-1:0] stack_top_reg [NUM_STACKS];
    logic [PTR_W-1:0] free_head_reg;
    logic [PTR_W-1:0] fill_reg;

    // Latched request
    logic              req_type_reg;
    logic [SID_W-1:0]  sid_reg;
    logic [DATA_W-1:0] value_reg;
    logic [PTR_W-1:0]  idx_reg;

    // Result
    logic              done_reg;
    status_t           status_reg;
    logic [DATA_W-1:0] pop_value_reg;

    logic [PTR_W-1:0] idx_sel;
    logic             sid_ok;
    logic             is_entry;
    logic [PTR_W-1:0] eff_link;
    logic             push_ok;
    logic             pop_ok;
    logic             link_we;
    logic [PTR_W-1:0] link_wdata;
    status_t          status_next;
    logic [DATA_W-1:0] pop_value_next;

    // Pick the entry the request works on: free-list head or stack top
    assign idx_sel = (req_type == REQ_POP) ? stack_top_reg[stack_id] : free_head_reg;

    assign sid_ok   = (32'(sid_reg) < NUM_STACKS);
    assign is_entry = (idx_reg < LINK_NULL);

    // Entries at or above the fill count were never written: link is next entry
    assign eff_link = (idx_reg >= fill_reg) ? (idx_reg + PTR_W'(1)) : link_rd_reg;

    assign push_ok = cmd.exec && sid_ok && is_entry && (req_type_reg == REQ_PUSH);
    assign pop_ok  = cmd.exec && sid_ok && is_entry && (req_type_reg == REQ_POP);

    assign link_we    = push_ok || pop_ok;
    assign link_wdata = push_ok ? stack_top_reg[sid_reg] : free_head_reg;

    // Form the result of the request
    always_comb
    begin
        pop_value_next = '0;
        if (push_ok || pop_ok)
        begin
            status_next = ST_OK;
        end
        else if (req_type_reg == REQ_POP)
        begin
            status_next = ST_EMPTY;
        end
        else
        begin
            status_next = ST_FULL;
        end
        if (pop_ok)
        begin
            pop_value_next = data_rd_reg;
        end
    end

    // Data memory: write on push, read at request accept
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            data_mem[idx_reg[IDX_W-1:0]] <= value_reg;
        end
        if (cmd.load)
        begin
            data_rd_reg <= data_mem[idx_sel[IDX_W-1:0]];
        end
    end

    // Link memory: write back on every successful request
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[idx_reg[IDX_W-1:0]] <= link_wdata;
        end
        if (cmd.load)
        begin
            link_rd_reg <= link_mem[idx_sel[IDX_W-1:0]];
        end
    end

    // Latch the request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= req_type;
            sid_reg      <= stack_id;
            value_reg    <= push_value;
            idx_reg      <= idx_sel;
        end
    end

    // Update stack tops, free-list head and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                stack_top_reg[i] <= LINK_NULL;
            end
            free_head_reg <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                free_head_reg          <= eff_link;
                stack_top_reg[sid_reg] <= idx_reg;
                if (idx_reg == fill_reg)
                begin
                    fill_reg <= fill_reg + PTR_W'(1);
                end
            end
            else if (pop_ok)
            begin
                stack_top_reg[sid_reg] <= eff_link;
                free_head_reg          <= idx_reg;
            end
        end
    end

    // Hold the result for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg    <= status_next;
            pop_value_reg <= pop_value_next;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign pop_value = pop_value_reg;

    `ASSERT_SAME(a_fill_in_range, 1'b1, fill_reg <= LINK_NULL)
    `ASSERT_NEXT(a_done_follows_exec, cmd.exec, done_reg)
    `ASSERT_SAME(a_refused_gives_zero, done_reg && (status_reg != ST_OK), pop_value_reg == '0)

endmodule

>>> design/multi_stack_shared_pool.sv
// Top level of the shared-pool stack block: controller plus datapath.
`timescale 1ns / 1ps

// Four LIFO stacks share one pool of 256 entries chained by a free list.
// Request channel: drive req_type (0 push, 1 pop), stack_id and push_value
// and raise start; the request is taken at the clock edge where start is
// high and busy is low.
// Result channel: done is high for exactly one cycle with status
// (0 ok, 1 pool full, 2 stack empty) and pop_value (popped value on a good
// pop, zero otherwise). The receiver cannot stall and must take it then.
// Done is registered from the execute state that follows the accept.
// Requests are not overlapped: the accept edge reads the link
// and data RAMs at the chosen entry; the execute state writes the links back and
// updates the stack tops and free-list head, so busy is high for one cycle.
// The next request may be taken while the result is still on the ports.
// Reset: all stacks empty, the free list runs through the pool in order.
// A fill count stands in for the link RAM's initial contents, so no
// clearing pass follows reset and a request can be taken straight away.
module multi_stack_shared_pool (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              req_type,
    input  logic [msp_pkg::SID_W-1:0]         stack_id,
    input  logic signed [msp_pkg::DATA_W-1:0] push_value,
    output logic                              done,
    output logic [1:0]                        status,
    output logic signed [msp_pkg::DATA_W-1:0] pop_value
);
    import msp_pkg::*;

    msp_cmd_t cmd;

    // Sequence each request
    msp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Pool storage and stack bookkeeping
    msp_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req_type   (req_type),
        .stack_id   (stack_id),
        .push_value (push_value),
        .done       (done),
        .status     (status),
        .pop_value  (pop_value)
    );

endmodule

>>> tb/sv/msp_result_checker.sv
// Checker that predicts and compares the results of the shared-pool stack block.
`timescale 1ns / 1ps

module msp_result_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              req_type,
    input  logic [msp_pkg::SID_W-1:0]         stack_id,
    input  logic signed [msp_pkg::DATA_W-1:0] push_value,
    input  logic                              done,
    input  logic [1:0]                        status,
    input  logic signed [msp_pkg::DATA_W-1:0] pop_value,
    output int                                mismatch_count,
    output int                                awaiting
);
    import msp_pkg::*;

    typedef struct {
        status_t           status;
        logic [DATA_W-1:0] value;
    } outcome_t;

    // Private copy of the pool, its links, the stack tops and the free list
    logic [DATA_W-1:0] pool_value [POOL_SIZE];
    logic [PTR_W-1:0]  pool_next [POOL_SIZE];
    logic [PTR_W-1:0]  top_of [NUM_STACKS];
    logic [PTR_W-1:0]  free_ptr;

    outcome_t outcome_q [$];
    int       fault_total = 0;
    int       pending = 0;

    assign mismatch_count = fault_total;
    assign awaiting       = pending;

    task automatic flag_mismatch(input string what);
        $display("%0t ns: stack pool mismatch: %s", $realtime, what);
        fault_total++;
    endtask

    // Apply one request to the private pool and work out its result
    task automatic apply_request(
        input  logic              kind,
        input  logic [SID_W-1:0]  sid,
        input  logic [DATA_W-1:0] value,
        output outcome_t          res
    );
        logic [PTR_W-1:0] slot;
        res.status = ST_OK;
        res.value  = '0;
        if (int'(sid) >= NUM_STACKS)
        begin
            res.status = (kind == REQ_POP) ? ST_EMPTY : ST_FULL;
        end
        else if (kind == REQ_PUSH)
        begin
            slot = free_ptr;
            if (slot >= PTR_W'(POOL_SIZE))
                res.status = ST_FULL;
            else
            begin
                free_ptr                   = pool_next[slot[IDX_W-1:0]];
                pool_value[slot[IDX_W-1:0]] = value;
                pool_next[slot[IDX_W-1:0]]  = top_of[sid];
                top_of[sid]                = slot;
            end
        end
        else
        begin
            slot = top_of[sid];
            if (slot >= PTR_W'(POOL_SIZE))
                res.status = ST_EMPTY;
            else
            begin
                top_of[sid]                = pool_next[slot[IDX_W-1:0]];
                pool_next[slot[IDX_W-1:0]] = free_ptr;
                free_ptr                   = slot;
                res.value                  = pool_value[slot[IDX_W-1:0]];
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            // Free list runs through the pool in order, every stack empty
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                pool_value[i] = '0;
                pool_next[i]  = PTR_W'(i + 1);
            end
            pool_next[POOL_SIZE-1] = LINK_NULL;
            for (int s = 0; s < NUM_STACKS; s++)
                top_of[s] = LINK_NULL;
            free_ptr = '0;
            outcome_q.delete();
        end
        else
        begin
            // Compare a result with the oldest prediction
            if (done === 1'b1)
            begin
                if (outcome_q.size() == 0)
                    flag_mismatch($sformatf("result with nothing outstanding, status %0d",
                                            status));
                else
                begin
                    want = outcome_q.pop_front();
                    if (status !== want.status)
                        flag_mismatch($sformatf("status %0d, predicted %0d",
                                                status, want.status));
                    if (pop_value !== want.value)
                        flag_mismatch($sformatf("pop_value %h, predicted %h",
                                                pop_value, want.value));
                end
            end
            // Predict each request taken at this edge
            if (start === 1'b1 && busy === 1'b0)
            begin
                apply_request(req_type, stack_id, push_value, want);
                outcome_q.push_back(want);
            end
        end
        pending = outcome_q.size();
    end

endmodule

>>> tb/sv/tb_multi_stack_shared_pool.sv
// Testbench top for the shared-pool stack block: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module tb_multi_stack_shared_pool;
    import msp_pkg::*;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     start      = 1'b0;
    logic                     req_type   = REQ_PUSH;
    logic [SID_W-1:0]         stack_id   = '0;
    logic signed [DATA_W-1:0] push_value = '0;
    logic                     busy;
    logic                     done;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] pop_value;
    int                       mismatch_count;
    int                       awaiting;
    bit                       idle_off = 1'b0;

    always #4 clk = ~clk;

    multi_stack_shared_pool dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .stack_id   (stack_id),
        .push_value (push_value),
        .done       (done),
        .status     (status),
        .pop_value  (pop_value)
    );

    msp_result_checker u_result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .stack_id       (stack_id),
        .push_value     (push_value),
        .done           (done),
        .status         (status),
        .pop_value      (pop_value),
        .mismatch_count (mismatch_count),
        .awaiting       (awaiting)
    );

    // Offer one request and hold it until the block takes it
    task automatic issue_request(
        input logic              kind,
        input logic [SID_W-1:0]  sid,
        input logic [DATA_W-1:0] value
    );
        // Idle at random with junk on the fields
        if (!idle_off)
        begin
            while ($urandom_range(0, 99) < 15)
            begin
                start      <= 1'b0;
                req_type   <= 1'($urandom);
                stack_id   <= SID_W'($urandom);
                push_value <= $urandom;
                @(posedge clk);
            end
        end
        start      <= 1'b1;
        req_type   <= kind;
        stack_id   <= sid;
        push_value <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int               push_pct [5];
        logic             kind;
        logic [SID_W-1:0] sid;
        logic [SID_W-1:0] favour;

        push_pct = '{85, 15, 50, 90, 10};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pop every empty stack, with a value that must be ignored
        for (int s = 0; s < NUM_STACKS; s++)
            issue_request(REQ_POP, SID_W'(s), $urandom | 32'h1);

        // Push the extremes, one per stack, then two more on stack zero
        issue_request(REQ_PUSH, 2'd0, 32'h8000_0000);
        issue_request(REQ_PUSH, 2'd1, 32'h7FFF_FFFF);
        issue_request(REQ_PUSH, 2'd2, 32'h0000_0000);
        issue_request(REQ_PUSH, 2'd3, 32'hFFFF_FFFF);
        issue_request(REQ_PUSH, 2'd0, 32'h5555_5555);
        issue_request(REQ_PUSH, 2'd0, 32'hAAAA_AAAA);

        // Drain stack zero past its bottom, then the others
        repeat (4) issue_request(REQ_POP, 2'd0, $urandom);
        issue_request(REQ_POP, 2'd1, $urandom);
        issue_request(REQ_POP, 2'd2, $urandom);
        issue_request(REQ_POP, 2'd3, $urandom);
        issue_request(REQ_POP, 2'd3, $urandom);

        // Phases fill the pool, drain it, mix evenly, then fill and drain again
        for (int ph = 0; ph < 5; ph++)
        begin
            idle_off = (ph == 2);
            favour   = SID_W'($urandom);
            for (int n = 0; n < 400; n++)
            begin
                kind = ($urandom_range(0, 99) < push_pct[ph]) ? REQ_PUSH : REQ_POP;
                // Odd phases pile most requests onto one stack for long chains
                if (ph % 2 == 1 && $urandom_range(0, 3) != 0)
                    sid = favour;
                else
                    sid = SID_W'($urandom);
                issue_request(kind, sid, $urandom);
            end
        end
        idle_off = 1'b0;
        start <= 1'b0;

        // Wait for the last results before the verdict
        do
            @(negedge clk);
        while (awaiting != 0);
        repeat (4) @(posedge clk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
